### rtl/tts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants
// index width, restart reset value and the payload structs of the converter
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int unsigned INDEX_W = 16;
    localparam logic [INDEX_W-1:0] RESTART_RESET = 16'hFFFF;

    typedef logic [INDEX_W-1:0] t_index;

    // one strip index from the input side
    typedef struct packed {
        t_index vertex_index;
        logic   end_of_list;
    } t_in_item;

    // one triangle toward the result side
    typedef struct packed {
        t_index corner_a;
        t_index corner_b;
        t_index corner_c;
    } t_out_item;

    // triangle as found by the front, before the winding swap
    typedef struct packed {
        t_index older;
        t_index newer;
        t_index latest;
        logic   odd;
    } t_tri_entry;

endpackage : tts_pkg
`default_nettype wire

### rtl/tts_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tts_front: strip tracking
// keeps the segment history, spots restarts and degenerate triangles
// ----------------------------------------------------------------------------
module tts_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire tts_pkg::t_index    i_cfg_data,
    input  wire logic               i_accept,
    input  wire tts_pkg::t_in_item  i_item,
    output logic                    o_emit,
    output tts_pkg::t_tri_entry     o_tri
);
    import tts_pkg::*;

    t_index     r_restart;
    t_index     r_older;
    t_index     r_newer;
    logic [1:0] r_fill;
    logic       r_odd;

    t_index     n_older;
    t_index     n_newer;
    logic [1:0] n_fill;
    logic       n_odd;

    logic is_restart;
    logic full_segment;
    logic distinct;

    assign is_restart   = (i_item.vertex_index == r_restart);
    assign full_segment = (r_fill == 2'd2);
    assign distinct     = (r_older != r_newer) && (r_newer != i_item.vertex_index)
                          && (r_older != i_item.vertex_index);

    assign o_emit = !is_restart && full_segment && distinct;
    assign o_tri  = '{older: r_older, newer: r_newer,
                      latest: i_item.vertex_index, odd: r_odd};

    always_comb begin
        n_older = r_older;
        n_newer = r_newer;
        n_fill  = r_fill;
        n_odd   = r_odd;
        if (!is_restart) begin
            if (full_segment) begin
                n_odd = !r_odd;
            end else begin
                n_fill = r_fill + 2'd1;
            end
            n_older = r_newer;
            n_newer = i_item.vertex_index;
        end
        // restart or end of list empties the segment
        if (is_restart || i_item.end_of_list) begin
            n_fill = 2'd0;
            n_odd  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restart <= RESTART_RESET;
            r_older   <= '0;
            r_newer   <= '0;
            r_fill    <= 2'd0;
            r_odd     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_restart <= i_cfg_data;
            end
            if (i_accept) begin
                r_older <= n_older;
                r_newer <= n_newer;
                r_fill  <= n_fill;
                r_odd   <= n_odd;
            end
        end
    end

endmodule : tts_front
`default_nettype wire

### rtl/tts_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tts_fifo: triangle queue
// short register queue between the strip front and the output stage
// ----------------------------------------------------------------------------
module tts_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr,
    input  wire tts_pkg::t_tri_entry  i_wr_data,
    input  wire logic                 i_rd,
    output tts_pkg::t_tri_entry       o_rd_data,
    output logic                      o_full,
    output logic                      o_empty
);
    import tts_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_tri_entry       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_wr;
    logic do_rd;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule : tts_fifo
`default_nettype wire

### rtl/tts_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tts_back: output stage
// applies the winding swap and holds the result until it is popped
// ----------------------------------------------------------------------------
module tts_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_empty,
    input  wire tts_pkg::t_tri_entry  i_q_data,
    output logic                      o_q_rd,
    input  wire logic                 i_pop,
    output logic                      o_empty,
    output tts_pkg::t_out_item        o_item
);
    import tts_pkg::*;

    logic      r_valid;
    t_out_item r_item;
    t_out_item n_item;

    assign o_q_rd  = !i_q_empty && (!r_valid || i_pop);
    assign o_empty = !r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item.corner_a = i_q_data.older;
        if (i_q_data.odd) begin
            n_item.corner_b = i_q_data.latest;
            n_item.corner_c = i_q_data.newer;
        end else begin
            n_item.corner_b = i_q_data.newer;
            n_item.corner_c = i_q_data.latest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_item <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_rd) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

endmodule : tts_back
`default_nettype wire

### rtl/tristrip_to_triangle_list_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tristrip_to_triangle_list_top: strip to triangle list converter
// turns a triangle strip index stream with primitive restart into triangles
// ----------------------------------------------------------------------------
// usage
//   input side is a queue write port: an index is transferred on a clock
//   edge with push high and full low; one index can be taken every cycle
//   result side is a queue read port: while empty is low the oldest triangle
//   sits on o_item and is transferred on an edge with pop high
//   an index equal to the restart register ends the strip segment; the first
//   two indices of a segment and degenerate triangles give no result, the
//   latter still flip the winding parity; end_of_list clears the segment
//   a closing index writes its triangle into the queue, and the output stage
//   loads the queue head once its result register is empty or being popped
//   throughput: one index per cycle while full is low, one triangle per cycle
//   while pop is high; the front's compare and history update set the rate
//   when the receiver stalls, triangles back up in the QUEUE_DEPTH entry
//   queue plus the output register; full rises only when the queue is full
//   reset (synchronous, active low) empties the segment and all queues and
//   loads the restart register with 0xffff; with no check in the block, the
//   user must write the restart register with i_cfg_we only while idle
// ----------------------------------------------------------------------------
module tristrip_to_triangle_list_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire tts_pkg::t_index    i_cfg_data,
    // index input
    input  wire logic               push,
    output logic                    full,
    input  wire tts_pkg::t_in_item  i_item,
    // triangle output
    output logic                    empty,
    input  wire logic               pop,
    output tts_pkg::t_out_item      o_item
);
    import tts_pkg::*;

    logic       accept;      // index transfer on this edge
    logic       emit;        // offered index would close a proper triangle
    t_tri_entry tri_new;
    t_tri_entry tri_head;
    logic       q_full;
    logic       q_empty;
    logic       q_rd;

    // front stalls only on a full queue
    assign full   = q_full;
    assign accept = push && !q_full;

    tts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_emit     (emit),
        .o_tri      (tri_new)
    );

    // decouples strip tracking from the receiver
    tts_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (accept && emit),
        .i_wr_data (tri_new),
        .i_rd      (q_rd),
        .o_rd_data (tri_head),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    // winding fix and result register
    tts_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (tri_head),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (o_item)
    );

endmodule : tristrip_to_triangle_list_top
`default_nettype wire

### tb/tb_tristrip_to_triangle_list_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_tristrip_to_triangle_list_top: testbench of the strip to triangle list converter
// feeds strip index streams with restarts, degenerate corners and end-of-list
// marks through the queue-style input, predicts every triangle in a small
// scoreboard and checks each triangle popped from the result side, under
// random sender bursts, receiver stalls and several restart register values
// ----------------------------------------------------------------------------
module tb_tristrip_to_triangle_list_top;
    import tts_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned RESET_CYCLES  = 5;
    // margin for the block to settle before touching config
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned PHASE_ITEMS   = 100;
    localparam int unsigned PHASE_COUNT   = 8;
    localparam int unsigned PRESSURE_LEN  = 60;

    // ------------------------------------------------------------------------
    // scoreboard: tracks the strip history and holds the triangles still due
    // ------------------------------------------------------------------------
    class strip_triangle_tracker;
        t_index      restart;
        t_index      older;
        t_index      newer;
        logic [1:0]  fill;
        logic        odd;
        t_out_item   due[$];
        int unsigned mismatches;

        function new();
            restart    = RESTART_RESET;
            older      = '0;
            newer      = '0;
            fill       = '0;
            odd        = 1'b0;
            mismatches = 0;
        endfunction

        function void set_restart(t_index value);
            restart = value;
        endfunction

        // an index was transferred into the block
        function void note_index(t_in_item item);
            t_out_item closed;
            t_index    v;
            v = item.vertex_index;
            if (v == restart) begin
                fill = '0;
                odd  = 1'b0;
            end else begin
                if (fill >= 2) begin
                    if (older != newer && newer != v && older != v) begin
                        closed.corner_a = older;
                        closed.corner_b = odd ? v : newer;
                        closed.corner_c = odd ? newer : v;
                        due = {due, closed};
                    end
                    // parity flips for dropped triangles too
                    odd = ~odd;
                end else begin
                    fill = fill + 2'd1;
                end
                older = newer;
                newer = v;
            end
            if (item.end_of_list) begin
                fill = '0;
                odd  = 1'b0;
            end
        endfunction

        function void report(string what, t_out_item want, t_out_item got);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("mismatch: %s exp a=%h b=%h c=%h got a=%h b=%h c=%h", what,
                         want.corner_a, want.corner_b, want.corner_c,
                         got.corner_a, got.corner_b, got.corner_c);
            end
        endfunction

        // a triangle was transferred out of the block
        function void check_triangle(t_out_item got);
            t_out_item want;
            if (due.size() == 0) begin
                report("triangle with none due", '0, got);
                return;
            end
            want = due.pop_front();
            if (got.corner_a != want.corner_a || got.corner_b != want.corner_b ||
                got.corner_c != want.corner_c) begin
                report("wrong triangle", want, got);
            end
        endfunction

        function int unsigned due_count();
            return due.size();
        endfunction

        function bit failed();
            return mismatches != 0;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals and the block
    // ------------------------------------------------------------------------
    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    t_index    i_cfg_data;
    logic      push;
    logic      full;
    t_in_item  i_item;
    logic      empty;
    logic      pop;
    t_out_item o_item;

    strip_triangle_tracker tracker = new();

    // restart value the stimulus currently targets
    t_index      active_restart = RESTART_RESET;
    // last two strip indices sent, used to build degenerate corners
    t_index      sent_prev1 = '0;
    t_index      sent_prev2 = '0;
    // set by the stimulus to ask the receiver for a long hold-off
    logic        hold_req = 1'b0;
    int unsigned cycle_count = 0;

    tristrip_to_triangle_list_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_item     (o_item)
    );

    // ------------------------------------------------------------------------
    // clock, cycle limit and transfer monitor
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // hang guard: nothing correct runs anywhere near this long
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // inputs only move on the falling edge, so both sides are stable here
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                tracker.note_index(i_item);
            end
            if (pop && !empty) begin
                tracker.check_triangle(o_item);
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: stall pattern of its own, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int unsigned hold_left;
        int unsigned mode;
        int unsigned mode_left;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        pop       = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (mode)
                    0: begin
                        // no stalls at all
                        pop <= 1'b1;
                    end
                    1: begin
                        pop <= ($urandom_range(0, 1) != 0);
                    end
                    2: begin
                        // mostly stalled
                        pop <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        pop <= ($urandom_range(0, 3) != 0);
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender side helpers, all entered and left at a falling edge
    // ------------------------------------------------------------------------
    function automatic t_in_item mk_item(t_index idx, logic eol);
        t_in_item item;
        item.vertex_index = idx;
        item.end_of_list  = eol;
        return item;
    endfunction

    // offer one index and hold it until the block takes it
    task automatic send_index(t_in_item item);
        push   <= 1'b1;
        i_item <= item;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
        @(negedge i_clk);
    endtask

    // sender idle, with junk on the payload lines
    task automatic idle_gap(int unsigned cycles);
        push   <= 1'b0;
        i_item <= t_in_item'($urandom());
        repeat (cycles) @(negedge i_clk);
    endtask

    // stop sending and wait until every due triangle has been popped
    task automatic drain_triangles();
        push <= 1'b0;
        while (tracker.due_count() != 0) @(negedge i_clk);
        // restarts and dropped triangles leave nothing due, let them settle
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_restart(t_index value);
        drain_triangles();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        tracker.set_restart(value);
        active_restart = value;
    endtask

    // mostly strip content, with restarts, repeats for degenerate corners,
    // values one bit away from the restart value and end-of-list marks
    function automatic t_in_item next_strip_item();
        t_in_item    item;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        item.end_of_list = ($urandom_range(0, 24) == 0);
        if (pick < 6) begin
            item.vertex_index = active_restart;
            item.end_of_list  = ($urandom_range(0, 3) == 0);
        end else if (pick < 14) begin
            item.vertex_index = ($urandom_range(0, 1) != 0) ? sent_prev1 : sent_prev2;
        end else if (pick < 19) begin
            item.vertex_index = active_restart ^ (t_index'(1) << $urandom_range(0, INDEX_W - 1));
        end else begin
            item.vertex_index = t_index'($urandom_range(0, 16'hFFFF));
        end
        if (item.vertex_index != active_restart) begin
            sent_prev2 = sent_prev1;
            sent_prev1 = item.vertex_index;
        end
        return item;
    endfunction

    task automatic send_random_items(int unsigned count);
        int unsigned burst_left;
        burst_left = $urandom_range(1, 24);
        repeat (count) begin
            send_index(next_strip_item());
            burst_left--;
            if (burst_left == 0) begin
                // mostly short gaps, now and then a long one
                if ($urandom_range(0, 7) == 0) begin
                    idle_gap($urandom_range(10, 30));
                end else begin
                    idle_gap($urandom_range(1, 8));
                end
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    // one long strip of distinct indices: every index past the second
    // closes a triangle, so the result side backs up during a hold-off
    task automatic send_long_strip(int unsigned count);
        t_index idx;
        idx = t_index'($urandom_range(0, 16'hFFFF));
        repeat (count) begin
            if (idx == active_restart) idx++;
            send_index(mk_item(idx, 1'b0));
            idx++;
        end
    endtask

    task automatic send_directed();
        // first strip, both winding orders, extreme indices
        send_index(mk_item(16'h0000, 1'b0));
        send_index(mk_item(16'hFFFE, 1'b0));
        send_index(mk_item(16'h0001, 1'b0));
        send_index(mk_item(16'h0002, 1'b0));
        send_index(mk_item(16'h0003, 1'b0));
        // plain restart
        send_index(mk_item(16'hFFFF, 1'b0));
        // degenerate triangles, each corner pair equal, parity still flips
        send_index(mk_item(16'h0005, 1'b0));
        send_index(mk_item(16'h0006, 1'b0));
        send_index(mk_item(16'h0006, 1'b0));
        send_index(mk_item(16'h0007, 1'b0));
        send_index(mk_item(16'h0005, 1'b0));
        send_index(mk_item(16'h0007, 1'b0));
        // end of list on an index that closes a triangle
        send_index(mk_item(16'h0008, 1'b1));
        // short segment cut by end of list
        send_index(mk_item(16'h0009, 1'b0));
        send_index(mk_item(16'h000A, 1'b1));
        // restart carrying end of list
        send_index(mk_item(16'h000B, 1'b0));
        send_index(mk_item(16'h000C, 1'b0));
        send_index(mk_item(16'hFFFF, 1'b1));
        // top bit patterns
        send_index(mk_item(16'h8000, 1'b0));
        send_index(mk_item(16'h7FFF, 1'b0));
        send_index(mk_item(16'hFFFE, 1'b0));
        send_index(mk_item(16'h0000, 1'b0));
        // short segment cut by a restart
        send_index(mk_item(16'hFFFF, 1'b0));
        send_index(mk_item(16'h1234, 1'b0));
        send_index(mk_item(16'hFFFF, 1'b0));
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_index phase_restart [PHASE_COUNT];
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        push       = 1'b0;
        i_item     = '0;

        // restart settings per phase, extremes first
        phase_restart[0] = 16'h0000;
        phase_restart[1] = 16'h8000;
        phase_restart[2] = 16'hFFFF;
        phase_restart[3] = t_index'($urandom_range(0, 16'hFFFF));
        phase_restart[4] = 16'h0001;
        phase_restart[5] = t_index'($urandom_range(0, 16'hFFFF));
        phase_restart[6] = 16'h7FFF;
        phase_restart[7] = t_index'($urandom_range(0, 16'hFFFF));

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part runs on the reset value of the restart register
        send_directed();

        for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
            // write_restart drains first, so the sender pauses until idle
            write_restart(phase_restart[p]);
            if (p == 1) begin
                // receiver holds off while the sender keeps offering
                hold_req = 1'b1;
                send_long_strip(PRESSURE_LEN);
            end
            send_random_items(PHASE_ITEMS);
        end

        drain_triangles();
        // anything still waiting at the output was never predicted
        if (tracker.failed() || !empty) begin
            $display("TB_ERROR");
        end else begin
            $display("TB_OK");
        end
        $finish;
    end

endmodule : tb_tristrip_to_triangle_list_top
`default_nettype wire
